// ----- hw/rtl/sf_pkg.sv -----
// Shared types, sizes and helpers for the segment finder.
`timescale 1ns / 1ps

package sf_pkg;

    // Store capacity and coordinate precision
    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 16;

    // Port widths fixed by the word format
    localparam int IN_W  = 16;
    localparam int TOP_W = 7;

    // Derived widths
    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    // Number of products the touch test needs per segment pair
    localparam int N_PROD = 16;
    localparam int N_TERM = 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;

    // One segment as held in the store
    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_seg;

    // Request tag travelling with a stored segment through the test pipe
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_tag;

    // Test outcome for one stored segment
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             hit;
    } t_res;

    // (a1 - a2) * (b1 - b2), exact
    function automatic t_prod mul_diff(input t_coord a1, input t_coord a2,
                                       input t_coord b1, input t_coord b2);
        t_diff da;
        t_diff db;
        da = t_diff'(a1) - t_diff'(a2);
        db = t_diff'(b1) - t_diff'(b2);
        return t_prod'(da) * t_prod'(db);
    endfunction

endpackage

// ----- hw/rtl/top_segment_finder.sv -----
// Segment finder top level: segment store, scan sequencer and result emission.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Words
// input     in         start high, busy low     i_start_x/y, i_end_x/y, i_last_segment
// result    out        o_strobe, one cycle      o_top_number, o_end_of_list, o_overflowed
//
// After its accept a segment holds busy while the segments already stored are read and
// tested (none when the store is empty or full): one stored segment per cycle leaves the
// single read port into the touch test pipe.
// A last segment then adds an emission pass over every stored entry; each result word is
// registered after its flag read, so the last word shows with busy low.
// Synchronous reset empties the store at once; results cannot be held off.

module top_segment_finder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [sf_pkg::IN_W-1:0] i_start_x,
    input  logic signed [sf_pkg::IN_W-1:0] i_start_y,
    input  logic signed [sf_pkg::IN_W-1:0] i_end_x,
    input  logic signed [sf_pkg::IN_W-1:0] i_end_y,
    input  logic                           i_last_segment,
    output logic                           o_strobe,
    output logic [sf_pkg::TOP_W-1:0]       o_top_number,
    output logic                           o_end_of_list,
    output logic                           o_overflowed
);
    import sf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;

    t_seg              r_mem [MAX_SEGMENTS];
    logic              r_cov_mem [MAX_SEGMENTS];
    t_seg              r_rd_data;
    logic              r_cov_rd;
    t_seg              r_cur;
    logic              r_last;
    logic [CNT_W-1:0]  r_count;
    logic              r_overflow;
    logic [CNT_W-1:0]  r_lim;
    logic [CNT_W-1:0]  r_issue_idx;
    logic              r_rd_valid;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_emit_idx;
    logic              r_emit_vld;
    logic [TOP_W-1:0]  r_emit_num;
    logic              r_emit_eol;
    logic              r_emit_ovf;

    logic  accept;
    logic  store_room;
    logic  rd_en;
    logic  cov_rd_en;
    logic  scan_done;
    logic  emit_last;
    t_seg  in_seg;
    t_tag  req;
    t_res  res;
    logic  pipe_busy;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign store_room = (r_count < CNT_W'(MAX_SEGMENTS));
    assign rd_en      = (r_state == S_SCAN) && (r_issue_idx < r_lim);
    assign cov_rd_en  = (r_state == S_EMIT);
    assign scan_done  = (r_issue_idx == r_lim) && !r_rd_valid && !pipe_busy;
    assign emit_last  = (r_emit_idx == IDX_W'(r_count - CNT_W'(1)));

    assign in_seg.sx = i_start_x[COORD_BITS-1:0];
    assign in_seg.sy = i_start_y[COORD_BITS-1:0];
    assign in_seg.ex = i_end_x[COORD_BITS-1:0];
    assign in_seg.ey = i_end_y[COORD_BITS-1:0];

    // Segment store: new word written on accept while there is room, scan reads registered
    always_ff @(posedge i_clk) begin
        if (accept && store_room) begin
            r_mem[r_count[IDX_W-1:0]] <= in_seg;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_issue_idx[IDX_W-1:0]];
        end
    end

    // Covered flags: cleared as an entry is stored, set on a hit, read during emission
    always_ff @(posedge i_clk) begin
        if (accept && store_room) begin
            r_cov_mem[r_count[IDX_W-1:0]] <= 1'b0;
        end else if (res.valid && res.hit) begin
            r_cov_mem[res.idx] <= 1'b1;
        end
        if (cov_rd_en) begin
            r_cov_rd <= r_cov_mem[r_emit_idx];
        end
    end

    // Probe segment held for the scan
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur  <= in_seg;
            r_last <= i_last_segment;
        end
    end

    assign req.valid = r_rd_valid;
    assign req.idx   = r_rd_idx;

    sf_touch_unit u_touch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_stored    (r_rd_data),
        .i_probe     (r_cur),
        .o_res       (res),
        .o_pipe_busy (pipe_busy)
    );

    // Sequencer, flags and registered result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_overflow    <= 1'b0;
            r_lim         <= '0;
            r_issue_idx   <= '0;
            r_rd_valid    <= 1'b0;
            r_rd_idx      <= '0;
            r_emit_idx    <= '0;
            r_emit_vld    <= 1'b0;
            r_emit_num    <= '0;
            r_emit_eol    <= 1'b0;
            r_emit_ovf    <= 1'b0;
            o_strobe      <= 1'b0;
            o_top_number  <= '0;
            o_end_of_list <= 1'b0;
            o_overflowed  <= 1'b0;
        end else begin
            r_rd_valid <= rd_en;
            r_rd_idx   <= r_issue_idx[IDX_W-1:0];

            // second emission stage: flag read is back, show the word
            r_emit_vld <= cov_rd_en;
            o_strobe   <= r_emit_vld && !r_cov_rd;
            if (r_emit_vld) begin
                o_top_number  <= r_emit_num;
                o_end_of_list <= r_emit_eol;
                o_overflowed  <= r_emit_ovf;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_issue_idx <= '0;
                        if (store_room) begin
                            r_lim   <= r_count;
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_lim      <= '0;
                            r_overflow <= 1'b1;
                        end
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (rd_en) begin
                        r_issue_idx <= r_issue_idx + CNT_W'(1);
                    end
                    if (scan_done) begin
                        r_emit_idx <= '0;
                        r_state    <= r_last ? S_EMIT : S_IDLE;
                    end
                end

                S_EMIT: begin
                    r_emit_num <= TOP_W'(r_emit_idx) + TOP_W'(1);
                    r_emit_eol <= emit_last;
                    r_emit_ovf <= r_overflow;
                    r_emit_idx <= r_emit_idx + IDX_W'(1);
                    if (emit_last) begin
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_emit_vld))
        else $error("result strobe outside emission");

    a_end_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_list && $past(r_emit_vld) |-> o_strobe)
        else $error("end of list on a covered entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond capacity");

    a_full_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !store_room |=> r_overflow)
        else $error("dropped segment not flagged");

endmodule

// ----- hw/rtl/sf_touch_unit.sv -----
// Pipelined touch test of one stored segment against the probe segment.
`timescale 1ns / 1ps

module sf_touch_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  sf_pkg::t_tag i_req,
    input  sf_pkg::t_seg i_stored,
    input  sf_pkg::t_seg i_probe,
    output sf_pkg::t_res o_res,
    output logic         o_pipe_busy
);
    import sf_pkg::*;

    t_prod n_prod [N_PROD];
    t_prod r_prod [N_PROD];
    t_tag  r_tag_a;

    logic [N_TERM-1:0] n_pos, n_neg, n_le;
    logic [N_TERM-1:0] r_pos, r_neg, r_le;
    t_tag  r_tag_b;

    logic [N_TERM-1:0] zero;
    logic              cross_hit;
    logic              end_hit;

    // Stage A: differences and products
    always_comb begin
        // orientation of the probe ends against the stored line
        n_prod[0]  = mul_diff(i_stored.ex, i_stored.sx, i_probe.sy, i_stored.sy);
        n_prod[1]  = mul_diff(i_stored.ey, i_stored.sy, i_probe.sx, i_stored.sx);
        n_prod[2]  = mul_diff(i_stored.ex, i_stored.sx, i_probe.ey, i_stored.sy);
        n_prod[3]  = mul_diff(i_stored.ey, i_stored.sy, i_probe.ex, i_stored.sx);
        // orientation of the stored ends against the probe line
        n_prod[4]  = mul_diff(i_probe.ex, i_probe.sx, i_stored.sy, i_probe.sy);
        n_prod[5]  = mul_diff(i_probe.ey, i_probe.sy, i_stored.sx, i_probe.sx);
        n_prod[6]  = mul_diff(i_probe.ex, i_probe.sx, i_stored.ey, i_probe.sy);
        n_prod[7]  = mul_diff(i_probe.ey, i_probe.sy, i_stored.ex, i_probe.sx);
        // betweenness of each end on the other segment
        n_prod[8]  = mul_diff(i_stored.sx, i_probe.sx, i_stored.ex, i_probe.sx);
        n_prod[9]  = mul_diff(i_stored.sy, i_probe.sy, i_stored.ey, i_probe.sy);
        n_prod[10] = mul_diff(i_stored.sx, i_probe.ex, i_stored.ex, i_probe.ex);
        n_prod[11] = mul_diff(i_stored.sy, i_probe.ey, i_stored.ey, i_probe.ey);
        n_prod[12] = mul_diff(i_probe.sx, i_stored.sx, i_probe.ex, i_stored.sx);
        n_prod[13] = mul_diff(i_probe.sy, i_stored.sy, i_probe.ey, i_stored.sy);
        n_prod[14] = mul_diff(i_probe.sx, i_stored.ex, i_probe.ex, i_stored.ex);
        n_prod[15] = mul_diff(i_probe.sy, i_stored.ey, i_probe.ey, i_stored.ey);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Stage B: sums reduced to sign flags
    always_comb begin
        t_sum cr;
        t_sum dt;
        for (int k = 0; k < N_TERM; k++) begin
            cr = t_sum'(r_prod[2*k]) - t_sum'(r_prod[2*k+1]);
            dt = t_sum'(r_prod[2*N_TERM+2*k]) + t_sum'(r_prod[2*N_TERM+2*k+1]);
            n_pos[k] = (cr > 0);
            n_neg[k] = (cr < 0);
            n_le[k]  = (dt <= 0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_neg <= n_neg;
        r_le  <= n_le;
    end

    // Tags follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else begin
            r_tag_a <= i_req;
            r_tag_b <= r_tag_a;
        end
    end

    // Stage C: decision
    assign zero      = ~(r_pos | r_neg);
    assign cross_hit = ((r_pos[0] & r_neg[1]) | (r_neg[0] & r_pos[1]))
                     & ((r_pos[2] & r_neg[3]) | (r_neg[2] & r_pos[3]));
    assign end_hit   = |(zero & r_le);

    assign o_res.valid = r_tag_b.valid;
    assign o_res.idx   = r_tag_b.idx;
    assign o_res.hit   = cross_hit | end_hit;

    assign o_pipe_busy = r_tag_a.valid | r_tag_b.valid;

endmodule
